/* sv/fifo_with_min_max_mean_macros.svh */
// ----------------------------------------------------------------------------
// fifo_with_min_max_mean_macros
// assertion macros shared by the fifo statistics block
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_MIN_MAX_MEAN_MACROS_SVH
`define FIFO_WITH_MIN_MAX_MEAN_MACROS_SVH

// property checked on every edge outside reset
`define FMMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent on one edge, consequent on the next
`define FMMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fmmm_pkg.sv */
// ----------------------------------------------------------------------------
// fmmm_pkg
// shared constants, status codes and state type of the fifo statistics block
// ----------------------------------------------------------------------------
package fmmm_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int MEAN_W    = 40;
	localparam int FRAC_W    = 8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DIV,
		S_DONE
	} fmmm_state_t;

endpackage

/* sv/fmmm_divider.sv */
// ----------------------------------------------------------------------------
// fmmm_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fmmm_divider #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != CNT_W'(1));
				done_q <= (cnt_q == CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// quotient bits shift in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

/* sv/fifo_with_min_max_mean.sv */
// An item is an enqueue (opcode 0) of value or a dequeue (opcode 1) of the
// oldest entry; each gives one result beat with status, the dequeued value,
// the fill count and the max, min and Q8 mean (truncated toward zero) of the
// entries held afterwards. Items are handled one at a time. An item that
// leaves the queue empty skips the scan and the divide; otherwise it takes
// one memory read per held entry for the min/max scan and a bit-serial
// divide, one step per bit of the 8 + 32 + clog2(DEPTH+1)-bit numerator.
// A new item is taken while the last result still waits.
// ----------------------------------------------------------------------------
// fifo_with_min_max_mean
// bounded fifo of signed words with max, min and mean after every operation
// ----------------------------------------------------------------------------
`include "fifo_with_min_max_mean_macros.svh"

module fifo_with_min_max_mean
	import fmmm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [VAL_W-1:0]  removed_value,
	output logic [CNT_W-1:0]         fill_count,
	output logic                     stats_valid,
	output logic signed [VAL_W-1:0]  largest,
	output logic signed [VAL_W-1:0]  smallest,
	output logic signed [MEAN_W-1:0] mean_q8
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = VAL_W + CNT_W;
	localparam int NUM_W = SUM_W + FRAC_W;

	fmmm_state_t state_q, state_d;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] mem_rd_q;
	logic [PTR_W-1:0] rd_addr;
	logic             mem_we;

	logic [PTR_W-1:0]        head_q, tail_q, scan_ptr_q;
	logic [CNT_W-1:0]        count_q, left_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    opcode_q;
	logic [VAL_W-1:0]        value_q;
	logic [1:0]              res_status_q;
	logic [VAL_W-1:0]        res_removed_q;
	logic                    rd_vld_s1, first_q, neg_q;
	logic signed [VAL_W-1:0] max_q, min_q;

	logic             enq_ok, deq_ok, scan_done, div_done, out_free;
	logic [CNT_W-1:0] count_next;
	logic [NUM_W-1:0] div_num, div_quot, quot_signed;
	logic [SUM_W-1:0] sum_mag;

	logic             out_valid_q, stats_valid_q;
	logic [1:0]       out_status_q;
	logic [VAL_W-1:0] out_removed_q, out_max_q, out_min_q;
	logic [CNT_W-1:0] out_count_q;
	logic [MEAN_W-1:0] out_mean_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign enq_ok    = (opcode_q == OP_ENQ) && (count_q != CNT_W'(DEPTH));
	assign deq_ok    = (opcode_q == OP_DEQ) && (count_q != '0);
	assign scan_done = (left_q == '0) && !rd_vld_s1;
	assign out_free  = !out_valid_q || out_ready;
	assign mem_we    = (state_q == S_EXEC) && enq_ok;
	assign rd_addr   = (state_q == S_SCAN) ? scan_ptr_q : head_q;
	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_num   = {sum_mag, {FRAC_W{1'b0}}};

	always_comb begin
		count_next = count_q;
		if (enq_ok) begin
			count_next = count_q + 1'b1;
		end else if (deq_ok) begin
			count_next = count_q - 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = (count_next == '0) ? S_DONE : S_SCAN;
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= value_q;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			left_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && (left_q != '0);
			if (state_q == S_EXEC) begin
				count_q <= count_next;
				left_q  <= count_next;
				if (enq_ok) begin
					tail_q <= ptr_inc(tail_q);
					sum_q  <= sum_q + SUM_W'(signed'(value_q));
				end else if (deq_ok) begin
					head_q <= ptr_inc(head_q);
					sum_q  <= sum_q - SUM_W'(signed'(mem_rd_q));
				end
			end else if ((state_q == S_SCAN) && (left_q != '0)) begin
				left_q <= left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_q <= opcode;
			value_q  <= value;
		end
		if (state_q == S_EXEC) begin
			if ((opcode_q == OP_ENQ) && !enq_ok) begin
				res_status_q  <= ST_FULL;
				res_removed_q <= '0;
			end else if ((opcode_q == OP_DEQ) && !deq_ok) begin
				res_status_q  <= ST_EMPTY;
				res_removed_q <= '0;
			end else begin
				res_status_q  <= ST_OK;
				res_removed_q <= deq_ok ? mem_rd_q : '0;
			end
			// scan starts at the head left by this operation
			scan_ptr_q <= deq_ok ? ptr_inc(head_q) : head_q;
			first_q    <= 1'b1;
		end else if (state_q == S_SCAN) begin
			if (left_q != '0) begin
				scan_ptr_q <= ptr_inc(scan_ptr_q);
			end
			if (rd_vld_s1) begin
				first_q <= 1'b0;
				if (first_q || (signed'(mem_rd_q) > max_q)) begin
					max_q <= signed'(mem_rd_q);
				end
				if (first_q || (signed'(mem_rd_q) < min_q)) begin
					min_q <= signed'(mem_rd_q);
				end
			end
			if (scan_done) begin
				neg_q <= sum_q[SUM_W-1];
			end
		end
	end

	fmmm_divider #(
		.NUM_W(NUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start ((state_q == S_SCAN) && scan_done),
		.num   (div_num),
		.den   (count_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign quot_signed = neg_q ? NUM_W'(-div_quot) : div_quot;

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_removed_q;
			out_count_q   <= count_q;
			stats_valid_q <= (count_q != '0);
			if (count_q == '0) begin
				out_max_q  <= '0;
				out_min_q  <= '0;
				out_mean_q <= '0;
			end else begin
				out_max_q  <= max_q;
				out_min_q  <= min_q;
				out_mean_q <= quot_signed[MEAN_W-1:0];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_value = out_removed_q;
	assign fill_count    = out_count_q;
	assign stats_valid   = stats_valid_q;
	assign largest       = out_max_q;
	assign smallest      = out_min_q;
	assign mean_q8       = out_mean_q;

	`FMMM_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "fill count above depth")
	`FMMM_ASSERT_NEXT(a_enq_count, (state_q == S_EXEC) && enq_ok,
		count_q == $past(count_q) + 1'b1, "enqueue did not bump the fill count")
	`FMMM_ASSERT_NEXT(a_deq_head, (state_q == S_EXEC) && deq_ok,
		head_q == ptr_inc($past(head_q)), "dequeue did not advance the head")
	`FMMM_ASSERT(a_stats_match, !out_valid_q || (stats_valid_q == (out_count_q != '0)),
		"stats flag disagrees with fill count")
	`FMMM_ASSERT(a_div_in_state, !div_done || (state_q == S_DIV),
		"divider finished outside the divide phase")

endmodule

/* test/fifo_with_min_max_mean_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_min_max_mean_tb
// Sends enqueue and dequeue beats in random bursts while the result side
// stalls in modes of its own. A shadow fifo tracks max, min and q8 mean for
// each accepted beat, and every result beat is checked against it field by field.
// ----------------------------------------------------------------------------
module fifo_with_min_max_mean_tb;
	import fmmm_pkg::*;

	localparam int FIFO_DEPTH    = DEPTH_DEF;
	localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
	localparam int RANDOM_OPS    = 450;
	localparam int SETTLE_CYCLES = 200;
	localparam int IDLE_LIMIT    = 4000;
	localparam int REPORT_MAX    = 10;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_SLOW
	} rx_mode_t;

	typedef struct {
		logic                    op;
		logic signed [VAL_W-1:0] val;
	} fifo_op_t;

	typedef struct {
		logic [1:0]               status;
		logic signed [VAL_W-1:0]  removed;
		logic [CNT_W-1:0]         fill;
		logic                     stats_ok;
		logic signed [VAL_W-1:0]  hi;
		logic signed [VAL_W-1:0]  lo;
		logic signed [MEAN_W-1:0] mean;
	} fifo_stats_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic                     opcode    = OP_ENQ;
	logic signed [VAL_W-1:0]  value     = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [1:0]               status;
	logic signed [VAL_W-1:0]  removed_value;
	logic [CNT_W-1:0]         fill_count;
	logic                     stats_valid;
	logic signed [VAL_W-1:0]  largest;
	logic signed [VAL_W-1:0]  smallest;
	logic signed [MEAN_W-1:0] mean_q8;

	fifo_op_t    ops_to_send[$];
	fifo_stats_t expected_stats[$];
	fifo_op_t    next_op;
	fifo_stats_t oldest_stats;

	// shadow copy of the queue contents
	logic signed [VAL_W-1:0] shadow_mem [FIFO_DEPTH];
	int     shadow_head  = 0;
	int     shadow_tail  = 0;
	int     shadow_count = 0;
	longint shadow_sum   = 0;

	int       gen_fill     = 0;
	int       mismatches   = 0;
	int       results_seen = 0;
	int       burst_left   = 0;
	int       gap_left     = 0;
	rx_mode_t rx_mode      = RX_OPEN;
	int       rx_left      = 0;
	int       idle_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fifo_with_min_max_mean dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.removed_value(removed_value),
		.fill_count   (fill_count),
		.stats_valid  (stats_valid),
		.largest      (largest),
		.smallest     (smallest),
		.mean_q8      (mean_q8)
	);

	function automatic fifo_stats_t apply_fifo_op(input logic op,
			input logic signed [VAL_W-1:0] val);
		fifo_stats_t r;
		int          p;
		longint      scaled;
		r = '{status: ST_OK, removed: '0, fill: '0, stats_ok: 1'b0,
			hi: '0, lo: '0, mean: '0};
		if (op == OP_ENQ) begin
			if (shadow_count >= FIFO_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_mem[shadow_tail] = val;
				shadow_tail = (shadow_tail + 1) % FIFO_DEPTH;
				shadow_count++;
				shadow_sum += longint'(val);
			end
		end else if (shadow_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.removed = shadow_mem[shadow_head];
			shadow_head = (shadow_head + 1) % FIFO_DEPTH;
			shadow_count--;
			shadow_sum -= longint'(r.removed);
		end
		r.fill = CNT_W'(shadow_count);
		if (shadow_count > 0) begin
			p = shadow_head;
			r.hi = shadow_mem[p];
			r.lo = shadow_mem[p];
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_mem[p] > r.hi)
					r.hi = shadow_mem[p];
				if (shadow_mem[p] < r.lo)
					r.lo = shadow_mem[p];
				p = (p + 1) % FIFO_DEPTH;
			end
			// longint division truncates toward zero
			scaled = shadow_sum * 256;
			r.mean = MEAN_W'(scaled / longint'(shadow_count));
			r.stats_ok = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 8))) - 4;
			3, 4: return $signed(32'($urandom_range(0, 600))) - 300;
			5: return 32'sh7FFFFFFF - $signed(32'($urandom_range(0, 1000)));
			6: return 32'sh80000000 + $signed(32'($urandom_range(0, 1000)));
			default: return $urandom;
		endcase
	endfunction

	// queue a beat for the driver and keep the generator's view of occupancy
	function automatic void push_op(input logic op, input logic signed [VAL_W-1:0] val);
		ops_to_send.push_back('{op: op, val: val});
		if (op == OP_ENQ && gen_fill < FIFO_DEPTH)
			gen_fill++;
		else if (op == OP_DEQ && gen_fill > 0)
			gen_fill--;
	endfunction

	task automatic check_field(input string what, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("result %0d: %s expected %0d, got %0d", results_seen, what,
					want, got);
		end
	endtask

	// driver: bursts of beats separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			opcode     <= OP_ENQ;
			value      <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_stats.push_back(apply_fifo_op(opcode, value));
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || ops_to_send.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0)
						gap_left <= gap_left - 1;
				end else begin
					next_op = ops_to_send.pop_front();
					in_valid <= 1'b1;
					opcode   <= next_op.op;
					value    <= next_op.val;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// monitor: checks result beats, ready follows a mode that changes now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode   <= RX_OPEN;
			rx_left   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result %0d: beat with nothing expected", results_seen);
				end else begin
					oldest_stats = expected_stats.pop_front();
					check_field("status", oldest_stats.status, status);
					check_field("removed_value", oldest_stats.removed, removed_value);
					check_field("fill_count", oldest_stats.fill, fill_count);
					check_field("stats_valid", oldest_stats.stats_ok, stats_valid);
					check_field("largest", oldest_stats.hi, largest);
					check_field("smallest", oldest_stats.lo, smallest);
					check_field("mean_q8", oldest_stats.mean, mean_q8);
				end
			end
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_left <= $urandom_range(20, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
				default:   out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[fifo_with_min_max_mean] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int seq_len;

		// dequeue on empty, extremes, mixed signs
		push_op(OP_DEQ, 32'sh0);
		push_op(OP_ENQ, 32'sh7FFFFFFF);
		push_op(OP_ENQ, 32'sh80000000);
		push_op(OP_ENQ, -32'sd1);
		push_op(OP_ENQ, 32'sh0);
		push_op(OP_ENQ, 32'sd1);
		// value is don't-care on dequeue
		push_op(OP_DEQ, 32'sh5A5A5A5A);
		push_op(OP_DEQ, 32'shA5A5A5A5);
		push_op(OP_DEQ, 32'sh0);
		push_op(OP_DEQ, -32'sd1);
		push_op(OP_DEQ, 32'sh0);
		push_op(OP_DEQ, 32'sh0);
		// negative mean that must truncate toward zero
		push_op(OP_ENQ, -32'sd1);
		push_op(OP_ENQ, 32'sh0);
		push_op(OP_ENQ, 32'sh0);
		push_op(OP_DEQ, 32'sh0);
		push_op(OP_DEQ, 32'sh0);
		push_op(OP_DEQ, 32'sh0);
		// biggest positive sum
		push_op(OP_ENQ, 32'sh7FFFFFFF);
		push_op(OP_ENQ, 32'sh7FFFFFFF);
		push_op(OP_DEQ, 32'sh0);
		push_op(OP_DEQ, 32'sh0);

		sent = 0;
		while (sent < RANDOM_OPS) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					// fill to the top, then knock on the full queue
					seq_len = FIFO_DEPTH - gen_fill + $urandom_range(1, 3);
					repeat (seq_len) push_op(OP_ENQ, pick_value());
				end
				2, 3: begin
					seq_len = gen_fill + $urandom_range(1, 2);
					repeat (seq_len) push_op(OP_DEQ, $urandom);
				end
				default: begin
					seq_len = $urandom_range(8, 40);
					repeat (seq_len)
						push_op($urandom_range(0, 1) ? OP_DEQ : OP_ENQ, pick_value());
				end
			endcase
			sent += seq_len;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (ops_to_send.size() != 0 || in_valid || expected_stats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[fifo_with_min_max_mean] OK");
		else
			$display("[fifo_with_min_max_mean] ERROR");
		$finish;
	end

endmodule
